// ===== sv/eust_pkg.sv =====
// Shared types and constants for the EU summer time flag block.
// Depends on nothing; eust_quot, eust_rule and the top level import it.
package eust_pkg;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
    } date_t;

    typedef struct packed {
        logic summer_time;
    } result_t;

    // Quotient stage to weekday stage: the registered date and the century terms.
    typedef struct packed {
        date_t      date;
        logic [7:0] q100;
        logic [5:0] q400;
    } quot_t;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2**14.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [3:0] MONTH_MAR = 4'd3;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_OCT = 4'd10;

    localparam logic [4:0] HOUR_ZERO = 5'd0;
    localparam logic [4:0] HOUR_ONE  = 5'd1;
    localparam logic [4:0] HOUR_TWO  = 5'd2;

    localparam logic [4:0] LAST_DAY = 5'd31;

    // Day-number constant for the 31st, reduced modulo 7: the month term plus 30 plus 3.
    localparam logic [2:0] MAR_OFFSET = 3'd5;
    localparam logic [2:0] OCT_OFFSET = 3'd2;

endpackage

// ===== sv/eust_stream_if.sv =====
// Valid/ready stream channel used for both the date and the flag side.
// The payload type is set where the channel is instantiated.
interface eust_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/eust_quot.sv =====
// Input register and century-quotient stage of the EU summer time flag.
// Uses eust_pkg for the date and quotient types and the reciprocal constant.
module eust_quot (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  eust_pkg::date_t in_data,
    output logic           in_ready,
    output logic           q_valid,
    output eust_pkg::quot_t q_data,
    input  logic           q_ready
);
    import eust_pkg::*;

    logic        s1_valid_reg;
    date_t       s1_data_reg;
    logic        q_valid_reg;
    quot_t       q_data_reg;
    logic        q_open;
    logic        s1_move;
    logic [11:0] q4;
    logic [26:0] prod100;
    logic [24:0] prod400;

    assign q_open   = !q_valid_reg || q_ready;
    assign s1_move  = s1_valid_reg && q_open;
    assign in_ready = !s1_valid_reg || q_open;

    // floor(y/400) is floor(floor(y/4)/100), so both quotients share one reciprocal.
    assign q4      = s1_data_reg.year[13:2];
    assign prod100 = 27'(s1_data_reg.year) * 27'(RECIP_100);
    assign prod400 = 25'(q4) * 25'(RECIP_100);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            q_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (q_open)
                q_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_data_reg <= in_data;
        if (s1_move)
        begin
            q_data_reg.date <= s1_data_reg;
            q_data_reg.q100 <= prod100[RECIP_SHIFT +: 8];
            q_data_reg.q400 <= prod400[RECIP_SHIFT +: 6];
        end
    end

    assign q_valid = q_valid_reg;
    assign q_data  = q_data_reg;

endmodule

// ===== sv/eust_rule.sv =====
// Weekday, last-Sunday and changeover decision stage with the result register.
// Uses eust_pkg for the month, hour and offset constants.
module eust_rule (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  eust_pkg::quot_t q_data,
    output logic            q_ready,
    output logic            out_valid,
    output eust_pkg::result_t out_data,
    input  logic            out_ready
);
    import eust_pkg::*;

    logic        out_valid_reg;
    result_t     out_data_reg;
    logic        moved_back_reg;
    logic        moved_back_next;
    logic        summer;
    logic        load;
    logic [2:0]  offset;
    logic [14:0] dn;
    logic [4:0]  sunday;
    date_t       d;

    // Residue modulo 7 by folding octal digits, since 8 is 1 modulo 7.
    function automatic logic [2:0] mod7(input logic [14:0] v);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [2:0] s3;
        s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        s3 = s2[2:0] + 3'(s2[3]);
        return (s3 == 3'd7) ? 3'd0 : s3;
    endfunction

    assign d       = q_data.date;
    assign q_ready = !out_valid_reg || out_ready;
    assign load    = q_valid && q_ready;

    always_comb
    begin
        offset = (d.month == MONTH_MAR) ? MAR_OFFSET : OCT_OFFSET;
        // 365*y is y modulo 7, so the day number reduces to these terms.
        dn = 15'(d.year) + 15'(d.year[13:2]) - 15'(q_data.q100)
           + 15'(q_data.q400) + 15'(offset);
        sunday = LAST_DAY - 5'(mod7(dn));

        summer          = 1'b0;
        moved_back_next = moved_back_reg;
        if (d.month inside {[MONTH_APR:MONTH_SEP]})
        begin
            summer = 1'b1;
        end
        else if (d.month == MONTH_MAR)
        begin
            if (d.day < sunday)
                summer = 1'b0;
            else if (d.day > sunday)
                summer = 1'b1;
            else
                summer = (d.hour >= HOUR_ONE);
        end
        else if (d.month == MONTH_OCT)
        begin
            if (d.day < sunday)
                summer = 1'b1;
            else if (d.day > sunday)
                summer = 1'b0;
            else if (d.hour == HOUR_ZERO)
            begin
                summer          = 1'b1;
                moved_back_next = 1'b0;
            end
            else if (d.hour == HOUR_ONE)
                summer = !moved_back_reg;
            else if (d.hour == HOUR_TWO)
            begin
                summer          = 1'b0;
                moved_back_next = 1'b1;
            end
            else
                summer = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            moved_back_reg <= 1'b0;
        end
        else
        begin
            if (q_ready)
                out_valid_reg <= q_valid;
            if (load)
                moved_back_reg <= moved_back_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg.summer_time <= summer;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_flag_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(moved_back_reg))
        else $error("moved_back changed without a request");

    a_hour_two_sets: assert property (@(posedge clk) disable iff (!rst_n)
        load && d.month == MONTH_OCT && d.day == sunday && d.hour == HOUR_TWO
        |=> moved_back_reg)
        else $error("hour 2 of the October changeover did not set moved_back");

    a_hour_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        load && d.month == MONTH_OCT && d.day == sunday && d.hour == HOUR_ZERO
        |=> !moved_back_reg)
        else $error("hour 0 of the October changeover did not clear moved_back");

    a_summer_months: assert property (@(posedge clk) disable iff (!rst_n)
        load && d.month >= MONTH_APR && d.month <= MONTH_SEP
        |=> out_valid_reg && out_data_reg.summer_time)
        else $error("April to September must give summer time");

    a_winter_months: assert property (@(posedge clk) disable iff (!rst_n)
        load && (d.month < MONTH_MAR || d.month > MONTH_OCT)
        |=> out_valid_reg && !out_data_reg.summer_time)
        else $error("months outside March to October must give normal time");

endmodule

// ===== sv/eu_summer_time_flag.sv =====
// EU summer time flag, top level.
// Channel stamp (sink) takes one request per cycle unless stalled: year, month,
// day and hour. Channel flag (source) returns one result per request:
// summer_time, 1 for summer time and 0 for normal time, in request order.
// A request accepted into the first register level moves through the second
// and third before its result is valid; while flag.ready stays high, one
// request per cycle is taken in steady state.
// The first register level holds the request, the second the century quotients
// from two constant multiplies, and the third the result and moved_back flag.
// When the receiver stalls, results wait in the output register and requests
// keep filling the two earlier levels; stamp.ready drops only when all three
// are full. Reset clears every valid bit and the moved_back flag, which
// remembers whether hour 2 of the October changeover day has been seen.
// Depends on eust_pkg, eust_stream_if, eust_quot and eust_rule.
module eu_summer_time_flag (
    input  logic                 clk,
    input  logic                 rst_n,
    eust_stream_if.sink          stamp,
    eust_stream_if.source        flag
);
    import eust_pkg::*;

    logic    q_valid;
    logic    q_ready;
    quot_t   q_data;
    date_t   in_data;
    result_t out_data;

    assign in_data = stamp.payload;

    eust_quot u_quot (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stamp.valid),
        .in_data  (in_data),
        .in_ready (stamp.ready),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_ready  (q_ready)
    );

    eust_rule u_rule (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_ready   (q_ready),
        .out_valid (flag.valid),
        .out_data  (out_data),
        .out_ready (flag.ready)
    );

    assign flag.payload = out_data;

endmodule
